// File: rtl/keutf8_pkg.sv
// Shared types and codes for the key event to UTF-8 byte encoder.
`default_nettype none
package keutf8_pkg;

   localparam logic [3:0] KIND_CHAR       = 4'd0;
   localparam logic [3:0] KIND_NAMED_LO   = 4'd1;
   localparam logic [3:0] KIND_NAMED_HI   = 4'd10;
   localparam logic [3:0] KIND_ENTER      = 4'd11;
   localparam logic [3:0] KIND_ESCAPE     = 4'd12;
   localparam logic [3:0] KIND_TAB        = 4'd13;

   localparam logic [3:0] NAMED_NONE      = 4'd0;

   typedef struct packed {
      logic [3:0]  key_kind;
      logic [20:0] key_code;
      logic        ctrl_held;
      logic        alt_held;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] named_key;
      logic       last;
   } rsp_type;

   // One classified event: up to four bytes, or one named key.
   typedef struct packed {
      logic [1:0]      num_minus_one;
      logic [3:0]      named_key;
      logic [3:0][7:0] bytes;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage
`default_nettype wire

// File: rtl/keutf8_front.sv
// Front end: classifies one key event and builds its byte command.
`default_nettype none
module keutf8_front (
   input  keutf8_pkg::req_type req_word,
   output keutf8_pkg::cmd_type cmd_word,
   output logic                cmd_valid
);

   localparam logic [7:0] BYTE_LF  = 8'd10;
   localparam logic [7:0] BYTE_ESC = 8'd27;
   localparam logic [7:0] BYTE_TAB = 8'd9;
   localparam logic [7:0] BYTE_FS  = 8'd28;
   localparam logic [7:0] BYTE_GS  = 8'd29;
   localparam logic [7:0] BYTE_RS  = 8'd30;
   localparam logic [7:0] BYTE_US  = 8'd31;
   localparam logic [7:0] BYTE_NUL = 8'd0;
   localparam logic [7:0] BYTE_DEL = 8'd127;

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } ctrl_res_type;

   function automatic ctrl_res_type ctrl_map(input logic [20:0] c);
      ctrl_res_type r;
      r.hit   = 1'b1;
      r.value = BYTE_NUL;
      case (c) inside
         [21'h61:21'h7A]: r.value = c[7:0] - 8'h60;
         [21'h41:21'h5A]: r.value = c[7:0] - 8'h40;
         21'h5B:          r.value = BYTE_ESC;
         21'h5C:          r.value = BYTE_FS;
         21'h5D:          r.value = BYTE_GS;
         21'h5E:          r.value = BYTE_RS;
         21'h5F, 21'h2F:  r.value = BYTE_US;
         21'h40, 21'h20:  r.value = BYTE_NUL;
         21'h3F:          r.value = BYTE_DEL;
         default:         r.hit   = 1'b0;
      endcase
      return r;
   endfunction

   ctrl_res_type ctrl_res;
   logic [20:0]  cp;

   assign cp       = req_word.key_code;
   assign ctrl_res = ctrl_map(cp);

   always_comb begin
      cmd_word           = '0;
      cmd_valid          = 1'b0;
      cmd_word.named_key = keutf8_pkg::NAMED_NONE;
      case (req_word.key_kind) inside
         [keutf8_pkg::KIND_NAMED_LO:keutf8_pkg::KIND_NAMED_HI]: begin
            cmd_valid          = 1'b1;
            cmd_word.named_key = req_word.key_kind;
         end
         keutf8_pkg::KIND_ENTER: begin
            cmd_valid         = 1'b1;
            cmd_word.bytes[0] = BYTE_LF;
         end
         keutf8_pkg::KIND_ESCAPE: begin
            cmd_valid         = 1'b1;
            cmd_word.bytes[0] = BYTE_ESC;
         end
         keutf8_pkg::KIND_TAB: begin
            cmd_valid         = 1'b1;
            cmd_word.bytes[0] = BYTE_TAB;
         end
         keutf8_pkg::KIND_CHAR: begin
            if (req_word.ctrl_held) begin
               cmd_valid         = ctrl_res.hit;
               cmd_word.bytes[0] = ctrl_res.value;
            end else if (!req_word.alt_held && cp <= 21'h10FFFF
                         && !(cp >= 21'h00D800 && cp <= 21'h00DFFF)) begin
               cmd_valid = 1'b1;
               if (cp < 21'h80) begin
                  cmd_word.bytes[0] = {1'b0, cp[6:0]};
               end else if (cp < 21'h800) begin
                  cmd_word.num_minus_one = 2'd1;
                  cmd_word.bytes[0]      = {3'b110, cp[10:6]};
                  cmd_word.bytes[1]      = {2'b10, cp[5:0]};
               end else if (cp < 21'h10000) begin
                  cmd_word.num_minus_one = 2'd2;
                  cmd_word.bytes[0]      = {4'b1110, cp[15:12]};
                  cmd_word.bytes[1]      = {2'b10, cp[11:6]};
                  cmd_word.bytes[2]      = {2'b10, cp[5:0]};
               end else begin
                  cmd_word.num_minus_one = 2'd3;
                  cmd_word.bytes[0]      = {5'b11110, cp[20:18]};
                  cmd_word.bytes[1]      = {2'b10, cp[17:12]};
                  cmd_word.bytes[2]      = {2'b10, cp[11:6]};
                  cmd_word.bytes[3]      = {2'b10, cp[5:0]};
               end
            end
         end
         default: cmd_valid = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/keutf8_queue.sv
// Short command queue between the classifier and the byte serialiser.
`default_nettype none
module keutf8_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  keutf8_pkg::cmd_type   wdata,
   input  logic                  pop,
   output keutf8_pkg::cmd_type   rdata,
   output keutf8_pkg::qstat_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   keutf8_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wdata;
   end

endmodule
`default_nettype wire

// File: rtl/keutf8_back.sv
// Back end: feeds the result register one head byte a cycle unless stalled.
`default_nettype none
module keutf8_back (
   input  logic                  clock,
   input  logic                  reset,
   input  keutf8_pkg::cmd_type   head,
   input  keutf8_pkg::qstat_type qstat,
   output logic                  head_pop,
   output keutf8_pkg::rsp_type   rsp_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop
);

   keutf8_pkg::rsp_type out_ff, out_in;
   logic                valid_ff, valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic                load, at_end;

   // the result register loads when it is empty or its word is taken, if a command is queued
   assign load     = !qstat.empty && (!valid_ff || rsp_pop);
   assign at_end   = (idx_ff == head.num_minus_one);
   assign head_pop = load && at_end;

   assign rsp_word  = out_ff;
   assign rsp_empty = !valid_ff;

   always_comb begin
      out_in   = out_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         out_in.out_byte  = head.bytes[idx_ff];
         out_in.named_key = head.named_key;
         out_in.last      = at_end;
         valid_in         = 1'b1;
         idx_in           = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

// File: rtl/key_event_to_utf8_bytes_core.sv
// Top level of the key event to UTF-8 byte encoder.
`default_nettype none
// One key event word in, zero to four result words out. Enter, Escape and Tab
// give one control byte, the ten navigation keys one named-key word, Ctrl with a
// mapped character its control byte, and a plain character its UTF-8 bytes lead
// first; Alt alone, unused kinds, unmapped Ctrl characters, surrogates and
// codepoints above 10FFFF give nothing. The front end takes one event per cycle
// while the command queue (QUEUE_DEPTH entries) has room; an event with no result
// leaves no trace. The back end sends one result word per cycle while the receiver
// takes them; with the queue empty, a first result word goes through the queue
// slot, then the result register, before it is on the result ports.
module key_event_to_utf8_bytes_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  keutf8_pkg::req_type req_word,
   input  logic                push,
   output logic                full,
   output keutf8_pkg::rsp_type rsp_word,
   output logic                empty,
   input  logic                pop
);

   keutf8_pkg::cmd_type   cmd_word, head;
   keutf8_pkg::qstat_type qstat;
   logic                  cmd_valid, head_pop;

   keutf8_front u_front (
      .req_word  (req_word),
      .cmd_word  (cmd_word),
      .cmd_valid (cmd_valid)
   );

   keutf8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push && cmd_valid),
      .wdata  (cmd_word),
      .pop    (head_pop),
      .rdata  (head),
      .status (qstat)
   );

   keutf8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .head_pop  (head_pop),
      .rsp_word  (rsp_word),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign full = qstat.full;

   a_named_last : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.named_key != keutf8_pkg::NAMED_NONE)
         |-> (rsp_word.last && rsp_word.out_byte == 8'd0))
      else $error("named-key word not a lone final word");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> empty)
      else $error("result word present straight after reset");

   a_pop_needs_result : assert property (@(posedge clock) disable iff (reset)
      head_pop |-> (!qstat.empty && (empty || pop)))
      else $error("command retired without its last word being loaded");

   a_cont_byte : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_word.last && rsp_word.named_key == keutf8_pkg::NAMED_NONE)
         |-> rsp_word.out_byte[7:6] == 2'b11 || rsp_word.out_byte[7:6] == 2'b10)
      else $error("non-final word is not a UTF-8 lead or continuation byte");

endmodule
`default_nettype wire

// File: test/key_event_to_utf8_bytes_core_tb.sv
// Self-checking testbench for the key event to UTF-8 byte encoder core.
module key_event_to_utf8_bytes_core_tb;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   localparam int LIMIT_CYCLES = 100000;
   localparam int IDLE_PERCENT = 16;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 150;

   localparam logic [7:0] BYTE_NUL = 8'd0;
   localparam logic [7:0] BYTE_TAB = 8'd9;
   localparam logic [7:0] BYTE_LF  = 8'd10;
   localparam logic [7:0] BYTE_ESC = 8'd27;
   localparam logic [7:0] BYTE_FS  = 8'd28;
   localparam logic [7:0] BYTE_GS  = 8'd29;
   localparam logic [7:0] BYTE_RS  = 8'd30;
   localparam logic [7:0] BYTE_US  = 8'd31;
   localparam logic [7:0] BYTE_DEL = 8'd127;

   localparam logic [3:0] KIND_UNUSED_LO = 4'd14;
   localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

   logic                clock;
   logic                reset;
   keutf8_pkg::req_type req_word;
   logic                push;
   logic                full;
   keutf8_pkg::rsp_type rsp_word;
   logic                empty;
   logic                pop;

   keutf8_pkg::rsp_type expected_words[$];
   bit      req_idle_on;
   bit      rsp_idle_on;
   int      rsp_hold_cycles;
   int      mismatches;
   int      events_sent;
   int      silent_events;
   int      words_checked;

   key_event_to_utf8_bytes_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .push     (push),
      .full     (full),
      .rsp_word (rsp_word),
      .empty    (empty),
      .pop      (pop)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("timeout: %0d result words still expected", expected_words.size());
      $display("** key_event_to_utf8_bytes_core: FAILED **");
      $finish;
   end

   function automatic keutf8_pkg::req_type key_event(input logic [3:0] kind,
                                                     input logic [20:0] code,
                                                     input bit ctrl, input bit alt);
      keutf8_pkg::req_type ev;
      ev.key_kind  = kind;
      ev.key_code  = code;
      ev.ctrl_held = ctrl;
      ev.alt_held  = alt;
      return ev;
   endfunction

   // Works out the words one key event gives and queues them, oldest first.
   function automatic void predict_words(input keutf8_pkg::req_type ev);
      logic [7:0]  bytes[4];
      logic [3:0]  named;
      logic [20:0] cp;
      logic [7:0]  c;
      int          n;
      keutf8_pkg::rsp_type w;
      n     = 0;
      named = keutf8_pkg::NAMED_NONE;
      cp    = ev.key_code;
      c     = cp[7:0];
      for (int i = 0; i < 4; i++) bytes[i] = BYTE_NUL;
      if (ev.key_kind >= keutf8_pkg::KIND_NAMED_LO
          && ev.key_kind <= keutf8_pkg::KIND_NAMED_HI) begin
         named = ev.key_kind;
         n     = 1;
      end else if (ev.key_kind == keutf8_pkg::KIND_ENTER) begin
         bytes[0] = BYTE_LF;
         n        = 1;
      end else if (ev.key_kind == keutf8_pkg::KIND_ESCAPE) begin
         bytes[0] = BYTE_ESC;
         n        = 1;
      end else if (ev.key_kind == keutf8_pkg::KIND_TAB) begin
         bytes[0] = BYTE_TAB;
         n        = 1;
      end else if (ev.key_kind != keutf8_pkg::KIND_CHAR) begin
         n = 0;
      end else if (ev.ctrl_held) begin
         // Ctrl takes precedence over Alt
         n = 1;
         if (cp[20:8] != 13'd0) n = 0;
         else if (c >= "a" && c <= "z") bytes[0] = c - "a" + 8'd1;
         else if (c >= "A" && c <= "Z") bytes[0] = c - "A" + 8'd1;
         else begin
            case (c)
               "[":      bytes[0] = BYTE_ESC;
               "\\":     bytes[0] = BYTE_FS;
               "]":      bytes[0] = BYTE_GS;
               "^":      bytes[0] = BYTE_RS;
               "_", "/": bytes[0] = BYTE_US;
               "@", " ": bytes[0] = BYTE_NUL;
               "?":      bytes[0] = BYTE_DEL;
               default:  n = 0;
            endcase
         end
      end else if (ev.alt_held) begin
         n = 0;
      end else if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
         n = 0;
      end else if (cp < 21'h80) begin
         bytes[0] = cp[7:0];
         n        = 1;
      end else if (cp < 21'h800) begin
         bytes[0] = {3'b110, cp[10:6]};
         bytes[1] = {2'b10, cp[5:0]};
         n        = 2;
      end else if (cp < 21'h10000) begin
         bytes[0] = {4'b1110, cp[15:12]};
         bytes[1] = {2'b10, cp[11:6]};
         bytes[2] = {2'b10, cp[5:0]};
         n        = 3;
      end else begin
         bytes[0] = {5'b11110, cp[20:18]};
         bytes[1] = {2'b10, cp[17:12]};
         bytes[2] = {2'b10, cp[11:6]};
         bytes[3] = {2'b10, cp[5:0]};
         n        = 4;
      end
      if (n == 0) silent_events++;
      for (int i = 0; i < n; i++) begin
         w.out_byte  = bytes[i];
         w.named_key = named;
         w.last      = (i == n - 1);
         expected_words.push_back(w);
      end
   endfunction

   function automatic keutf8_pkg::req_type random_key_event();
      keutf8_pkg::req_type ev;
      int      pick;
      ev.key_kind  = keutf8_pkg::KIND_CHAR;
      ev.key_code  = 21'($urandom());
      ev.ctrl_held = 1'b0;
      ev.alt_held  = 1'b0;
      pick         = $urandom_range(99);
      if (pick < 15) begin
         ev.key_kind  = 4'($urandom_range(keutf8_pkg::KIND_NAMED_LO, keutf8_pkg::KIND_TAB));
         ev.ctrl_held = 1'($urandom_range(1));
         ev.alt_held  = 1'($urandom_range(1));
      end else if (pick < 18) begin
         ev.key_kind  = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         ev.ctrl_held = 1'($urandom_range(1));
         ev.alt_held  = 1'($urandom_range(1));
      end else if (pick < 34) begin
         ev.ctrl_held = 1'b1;
         ev.alt_held  = 1'($urandom_range(1));
         case ($urandom_range(5))
            0: ev.key_code = 21'("a" + $urandom_range(25));
            1: ev.key_code = 21'("A" + $urandom_range(25));
            2: ev.key_code = 21'("[" + $urandom_range(4));
            3: begin
               case ($urandom_range(3))
                  0: ev.key_code = 21'("/");
                  1: ev.key_code = 21'("@");
                  2: ev.key_code = 21'(" ");
                  default: ev.key_code = 21'("?");
               endcase
            end
            4: ev.key_code = 21'($urandom_range(8'h7F));
            default: ;
         endcase
      end else if (pick < 39) begin
         ev.alt_held = 1'b1;
      end else if (pick < 47) begin
         if ($urandom_range(1)) ev.key_code = 21'(21'hD800 + $urandom_range(21'h7FF));
         else ev.key_code = 21'($urandom_range(21'h110000, 21'h1FFFFF));
      end else begin
         case ($urandom_range(3))
            0: ev.key_code = 21'($urandom_range(21'h7F));
            1: ev.key_code = 21'($urandom_range(21'h80, 21'h7FF));
            2: ev.key_code = 21'($urandom_range(21'h800, 21'hFFFF));
            default: ev.key_code = 21'($urandom_range(21'h10000, 21'h10FFFF));
         endcase
      end
      return ev;
   endfunction

   // Offers one event word and holds it until the core takes it.
   task automatic send_key(input keutf8_pkg::req_type ev);
      int gap;
      if (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_word <= ev;
      push     <= 1'b1;
      do @(posedge clock); while (full);
      predict_words(ev);
      events_sent++;
   endtask

   task automatic req_stop();
      @(negedge clock);
      push <= 1'b0;
   endtask

   task automatic wait_drain();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_special_keys();
      send_key(key_event(keutf8_pkg::KIND_NAMED_LO, 21'h1FFFFF, 1'b1, 1'b1));
      send_key(key_event(keutf8_pkg::KIND_NAMED_HI, 21'h0, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_ENTER, 21'h0, 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_ESCAPE, 21'h41, 1'b0, 1'b1));
      send_key(key_event(keutf8_pkg::KIND_TAB, 21'h1FFFFF, 1'b1, 1'b1));
      send_key(key_event(KIND_UNUSED_LO, 21'h41, 1'b0, 1'b0));
      send_key(key_event(KIND_UNUSED_HI, 21'h1FFFFF, 1'b1, 1'b1));
   endtask

   task automatic test_ctrl_map();
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("a"), 1'b1, 1'b1));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("Z"), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("["), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("\\"), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("]"), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("^"), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("/"), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'(" "), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("?"), 1'b1, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("5"), 1'b1, 1'b0));
   endtask

   task automatic test_utf8_edges();
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'("a"), 1'b0, 1'b1));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'h0, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'h80, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'h7FF, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'hFFFF, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'h10FFFF, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'h110000, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'hD800, 1'b0, 1'b0));
      send_key(key_event(keutf8_pkg::KIND_CHAR, 21'hDFFF, 1'b0, 1'b0));
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_key(random_key_event());
   endtask

   // Receiver stops for a long stretch; the first events sent are four-byte.
   task automatic test_full_stall(input int count);
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < count; i++) begin
         if (i < 16)
            send_key(key_event(keutf8_pkg::KIND_CHAR,
                               21'($urandom_range(21'h10000, 21'h10FFFF)), 1'b0, 1'b0));
         else send_key(random_key_event());
      end
   endtask

   task automatic test_no_idle(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (count) send_key(random_key_event());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_drain_pause(input int rounds, input int count);
      repeat (rounds) begin
         repeat (count) send_key(random_key_event());
         req_stop();
         wait_drain();
      end
   endtask

   task automatic report_mismatch(input string why, input keutf8_pkg::rsp_type want,
                                  input keutf8_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t (%s): expected byte %02h named %0d last %0b,%s",
                  $time, why, want.out_byte, want.named_key, want.last,
                  $sformatf(" got byte %02h named %0d last %0b",
                            got.out_byte, got.named_key, got.last));
   endtask

   // Receiver: pops at random, or not at all during a hold-off.
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) pop <= 1'b0;
         else if (rsp_hold_cycles > 0) begin
            pop <= 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_idle_on && $urandom_range(99) < IDLE_PERCENT) pop <= 1'b0;
         else pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      keutf8_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         words_checked++;
         if (expected_words.size() == 0) begin
            want = '0;
            report_mismatch("no word expected", want, rsp_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.out_byte !== want.out_byte || rsp_word.named_key !== want.named_key
                || rsp_word.last !== want.last)
               report_mismatch("wrong word", want, rsp_word);
         end
      end
   end

   initial begin
      reset           = 1'b1;
      push            = 1'b0;
      req_word        = '0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      rsp_hold_cycles = 0;
      mismatches      = 0;
      events_sent     = 0;
      silent_events   = 0;
      words_checked   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_keys();
      test_ctrl_map();
      test_utf8_edges();
      test_random_mix(280);
      test_full_stall(60);
      test_no_idle(60);
      test_drain_pause(2, 25);

      req_stop();
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d key events (%0d giving no output), checked %0d result words.",
               events_sent, silent_events, words_checked);
      $display("Covered named keys, Ctrl mapping, Alt drop, UTF-8 of all lengths,");
      $display("bad codepoints, a full stall and a drained pause.");
      if (mismatches == 0) $display("** key_event_to_utf8_bytes_core: PASSED **");
      else begin
         $display("%0d mismatches", mismatches);
         $display("** key_event_to_utf8_bytes_core: FAILED **");
      end
      $finish;
   end

endmodule
